// ===== rtl/murmur3_bloom_filter_macros.svh =====
// Assertion macros for the checker file.
`ifndef MURMUR3_BLOOM_FILTER_MACROS_SVH
`define MURMUR3_BLOOM_FILTER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MBF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/mbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbf_pkg: shared types and constants
// Murmur constants, configuration indexes, sequencer states and the multiplier request type.
// ----------------------------------------------------------------------------
package mbf_pkg;
  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [31:0] MIX_N  = 32'he6546b64;
  localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;
  localparam int SEED_REGS = 6;

  localparam logic [2:0] CFG_FILTER_BITS = 3'd0;
  localparam logic [2:0] CFG_HASH_COUNT  = 3'd1;
  localparam logic [2:0] CFG_SEED_ZERO   = 3'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCR1, ST_SCR2, ST_MIX, ST_FIN1, ST_FIN2, ST_FIN3,
    ST_MOD, ST_RD, ST_CHK, ST_WR, ST_DONE
  } state_t;

  // Shared multiplier operand select: product is a * b (low 32 bits).
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;
endpackage

// ===== rtl/mbf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbf_mul: shared 32x32 multiplier
// One registered low-half product per cycle, used by the key scramble and the finalizer.
// ----------------------------------------------------------------------------
module mbf_mul (
  input  logic               clk,
  input  mbf_pkg::mul_req_t  req,
  output logic [31:0]        prod_r
);
  logic [31:0] prod_nxt;
  assign prod_nxt = req.a * req.b;
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end
endmodule

// ===== rtl/mbf_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbf_mod: iterative modulo unit
// Restoring reduction of a 32-bit value by the filter size, one bit a cycle.
// ----------------------------------------------------------------------------
module mbf_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done_r,
  output logic [31:0] rem_r
);
  logic [31:0] num_r, num_nxt, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_nxt;
  logic [32:0] sh;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, num_r[31]};
    if (go) begin
      num_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[30:0], 1'b0};
      rem_nxt = (sh >= {1'b0, den}) ? 32'(sh - {1'b0, den}) : sh[31:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end
endmodule

// ===== rtl/murmur3_bloom_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_bloom_filter: Bloom filter keyed by MurmurHash3_32
// Hashes keys word by word with per-lane seeds and sets or probes store bits.
// ----------------------------------------------------------------------------
// Channel  | Ports                                          | Handshake
// input    | in_mode in_key_word in_word_bytes in_last_word | start & !busy
// result   | out_is_member out_was_add                      | out_valid, one cycle
// config   | cfg_we cfg_index cfg_data                      | cfg_we
//
// While a word beat is worked on, busy stays high: two multiplies through the
// shared multiplier scramble the key word, then the lanes mix it into their
// hashes one after another (a rotate, shift and add for full words, a plain
// xor for a short tail); an empty last word skips both steps. A last word then
// probes each used hash in turn: ST_FIN1 to ST_FIN3 finalize it, the iterative
// modulo reduces it, then the store is read, checked and, when adding, written;
// ST_DONE carries the result. After reset the store is cleared one word a cycle
// while busy stays high. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module murmur3_bloom_filter #(
  parameter int MAX_FILTER_BITS = 65536,
  parameter int MAX_HASHES      = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_key_word,
  input  logic [2:0]  in_word_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  output logic        out_is_member,
  output logic        out_was_add,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int STORE_WORDS = MAX_FILTER_BITS / 64;
  localparam int AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int LANES = (MAX_HASHES < mbf_pkg::SEED_REGS) ? MAX_HASHES : mbf_pkg::SEED_REGS;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [31:0] SIZE_CAP = 32'(STORE_WORDS * 64);

  // Configuration registers.
  logic [16:0] filter_bits_r;
  logic [2:0]  hash_count_r;
  logic [31:0] seed_r [mbf_pkg::SEED_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bits_r <= 17'd65536;
      hash_count_r  <= 3'd6;
      for (int i = 0; i < mbf_pkg::SEED_REGS; i++) seed_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mbf_pkg::CFG_FILTER_BITS) filter_bits_r <= cfg_data[16:0];
      else if (cfg_index == mbf_pkg::CFG_HASH_COUNT) hash_count_r <= cfg_data[2:0];
      else seed_r[cfg_index - mbf_pkg::CFG_SEED_ZERO] <= cfg_data;
    end
  end

  // Effective filter size and probe count.
  logic [31:0] size_raw, size_eff;
  logic [LW:0] count_eff;
  always_comb begin
    size_raw = {15'd0, filter_bits_r[16:6], 6'd0};
    if (size_raw < 32'd64) size_eff = 32'd64;
    else if (size_raw > SIZE_CAP) size_eff = SIZE_CAP;
    else size_eff = size_raw;
    if (32'(hash_count_r) > 32'(LANES)) count_eff = (LW+1)'(LANES);
    else count_eff = (LW+1)'(hash_count_r);
  end

  // Bit store, one 64-bit word a row.
  logic [63:0] mem [STORE_WORDS];
  logic [63:0] rd_data_r;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [63:0]   mem_wdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_r <= mem[mem_addr];
  end

  // Sequencer state and data path registers.
  mbf_pkg::state_t state_r, state_nxt;
  logic            key_busy_r, key_busy_nxt;
  logic [31:0]     hash_r [LANES];
  logic [31:0]     klen_r, klen_nxt;
  logic [31:0]     k_r, k_nxt;
  logic [31:0]     h_r, h_nxt;
  logic [LW-1:0]   lane_r, lane_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic            member_r, member_nxt;
  logic            mode_r, last_r, full_r;
  logic            mod_go_r, mod_go_nxt;

  mbf_pkg::mul_req_t mreq;
  logic [31:0]       prod;
  logic              mod_done;
  logic [31:0]       mod_rem;
  logic [31:0]       fin_h;

  mbf_mul u_mul (.clk(clk), .req(mreq), .prod_r(prod));

  // The finalized hash enters the modulo unit straight from the multiplier in
  // the first cycle of ST_MOD.
  mbf_mod u_mod (.clk(clk), .rst_n(rst_n), .go(mod_go_r), .num(fin_h), .den(size_eff),
                 .done_r(mod_done), .rem_r(mod_rem));

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != mbf_pkg::ST_IDLE);

  // Masked tail word for short last words.
  logic [2:0]  nb_eff;
  logic [31:0] masked;
  always_comb begin
    nb_eff = (!in_last_word || in_word_bytes > 3'd4) ? 3'd4 : in_word_bytes;
    unique case (nb_eff)
      3'd1:    masked = {24'd0, in_key_word[7:0]};
      3'd2:    masked = {16'd0, in_key_word[15:0]};
      3'd3:    masked = {8'd0, in_key_word[23:0]};
      default: masked = in_key_word;
    endcase
  end

  // The scrambled key word leaves the multiplier in the first mix cycle and is
  // held in k_r for the remaining lanes.
  logic [31:0] cur_h, k_cur, mix_x, rot_h, mixed;
  logic [31:0] rot_k, fin_x, fin_in;
  assign cur_h  = hash_r[lane_r];
  assign k_cur  = (lane_r == '0) ? prod : k_r;
  assign mix_x  = cur_h ^ k_cur;
  assign rot_h  = {mix_x[18:0], mix_x[31:19]};
  assign mixed  = {rot_h[29:0], 2'b00} + rot_h + mbf_pkg::MIX_N;
  assign rot_k  = {prod[16:0], prod[31:17]};
  assign fin_x  = prod ^ {13'd0, prod[31:13]};
  assign fin_h  = prod ^ {16'd0, prod[31:16]};
  assign fin_in = cur_h ^ klen_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbf_pkg::ST_CLEAR: if (clr_r == AW'(STORE_WORDS - 1)) state_nxt = mbf_pkg::ST_IDLE;
      mbf_pkg::ST_IDLE: begin
        if (accept) begin
          if (nb_eff == 3'd0) state_nxt = mbf_pkg::ST_FIN1;
          else state_nxt = mbf_pkg::ST_SCR1;
        end
      end
      mbf_pkg::ST_SCR1: state_nxt = mbf_pkg::ST_SCR2;
      mbf_pkg::ST_SCR2: state_nxt = mbf_pkg::ST_MIX;
      mbf_pkg::ST_MIX: begin
        if (lane_r == LW'(LANES - 1)) begin
          if (last_r) state_nxt = mbf_pkg::ST_FIN1;
          else state_nxt = mbf_pkg::ST_IDLE;
        end
      end
      mbf_pkg::ST_FIN1: begin
        if (count_eff == '0) state_nxt = mbf_pkg::ST_DONE;
        else state_nxt = mbf_pkg::ST_FIN2;
      end
      mbf_pkg::ST_FIN2: state_nxt = mbf_pkg::ST_FIN3;
      mbf_pkg::ST_FIN3: state_nxt = mbf_pkg::ST_MOD;
      mbf_pkg::ST_MOD:  if (mod_done) state_nxt = mbf_pkg::ST_RD;
      mbf_pkg::ST_RD:   state_nxt = mbf_pkg::ST_CHK;
      mbf_pkg::ST_CHK:  state_nxt = mbf_pkg::ST_WR;
      mbf_pkg::ST_WR: begin
        if ((LW+1)'(lane_r) + 1'b1 == count_eff) state_nxt = mbf_pkg::ST_DONE;
        else state_nxt = mbf_pkg::ST_FIN1;
      end
      mbf_pkg::ST_DONE: state_nxt = mbf_pkg::ST_IDLE;
      default: state_nxt = mbf_pkg::ST_IDLE;
    endcase
  end

  // Data path and outputs.
  always_comb begin
    key_busy_nxt = key_busy_r;
    klen_nxt     = klen_r;
    k_nxt        = k_r;
    h_nxt        = h_r;
    lane_nxt     = lane_r;
    clr_nxt      = clr_r;
    pos_nxt      = pos_r;
    member_nxt   = member_r;
    mod_go_nxt   = 1'b0;
    mreq.a       = k_r;
    mreq.b       = mbf_pkg::MIX_C2;
    mem_we       = 1'b0;
    mem_addr     = pos_r[6 +: AW];
    mem_wdata    = rd_data_r | (64'd1 << pos_r[5:0]);
    unique case (state_r)
      mbf_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      mbf_pkg::ST_IDLE: begin
        lane_nxt   = '0;
        member_nxt = 1'b1;
        if (accept) begin
          key_busy_nxt = !in_last_word;
          klen_nxt     = (key_busy_r ? klen_r : 32'd0) + 32'(nb_eff);
          k_nxt        = masked;
        end
      end
      mbf_pkg::ST_SCR1: begin
        mreq.a = k_r;
        mreq.b = mbf_pkg::MIX_C1;
      end
      mbf_pkg::ST_SCR2: begin
        mreq.a = rot_k;
        mreq.b = mbf_pkg::MIX_C2;
      end
      mbf_pkg::ST_MIX: begin
        if (lane_r == '0) k_nxt = prod;
        if (lane_r == LW'(LANES - 1)) lane_nxt = '0;
        else lane_nxt = lane_r + 1'b1;
      end
      mbf_pkg::ST_FIN1: begin
        h_nxt = fin_in ^ {16'd0, fin_in[31:16]};
      end
      mbf_pkg::ST_FIN2: begin
        mreq.a = h_r;
        mreq.b = mbf_pkg::FIN_C1;
      end
      mbf_pkg::ST_FIN3: begin
        mreq.a     = fin_x;
        mreq.b     = mbf_pkg::FIN_C2;
        mod_go_nxt = 1'b1;
      end
      mbf_pkg::ST_MOD: begin
        if (mod_done) pos_nxt = mod_rem;
      end
      mbf_pkg::ST_RD: ;
      mbf_pkg::ST_CHK: begin
        if (!rd_data_r[pos_r[5:0]]) member_nxt = 1'b0;
      end
      mbf_pkg::ST_WR: begin
        mem_we   = mode_r;
        lane_nxt = lane_r + 1'b1;
      end
      mbf_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    klen_r   <= klen_nxt;
    k_r      <= k_nxt;
    h_r      <= h_nxt;
    pos_r    <= pos_nxt;
    member_r <= member_nxt;
    if (accept) begin
      mode_r <= in_mode;
      last_r <= in_last_word;
      full_r <= (nb_eff == 3'd4);
      if (!key_busy_r) for (int i = 0; i < LANES; i++) hash_r[i] <= seed_r[i];
    end
    if (state_r == mbf_pkg::ST_MIX) begin
      if (full_r) hash_r[lane_r] <= mixed;
      else hash_r[lane_r] <= mix_x;
    end
    if (!rst_n) begin
      state_r    <= mbf_pkg::ST_CLEAR;
      key_busy_r <= 1'b0;
      lane_r     <= '0;
      clr_r      <= '0;
      mod_go_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      key_busy_r <= key_busy_nxt;
      lane_r     <= lane_nxt;
      clr_r      <= clr_nxt;
      mod_go_r   <= mod_go_nxt;
    end
  end

  // The result is presented during ST_DONE, while busy is still high.
  assign out_valid     = (state_r == mbf_pkg::ST_DONE);
  assign out_is_member = member_r;
  assign out_was_add   = mode_r;
endmodule

// ===== rtl/mbf_checker.sv =====
`timescale 1ns / 1ps
`include "murmur3_bloom_filter_macros.svh"
// ----------------------------------------------------------------------------
// mbf_checker: port-level checks
// Watches the handshake and result ports of the top level.
// ----------------------------------------------------------------------------
module mbf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  `MBF_ASSERT_NEXT(a_result_single, clk, rst_n, out_valid, !out_valid)
  `MBF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)
  `MBF_ASSERT_IMP(a_result_not_idle, clk, rst_n, out_valid, busy)
  `MBF_ASSERT_NEXT(a_no_result_after_accept, clk, rst_n, start && !busy, !out_valid)
endmodule

bind murmur3_bloom_filter mbf_checker u_mbf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

// ===== tb/murmur3_bloom_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_bloom_filter_tb: self-checking bench for the murmur3 Bloom filter
// Drives directed and random keys through several filter settings and checks
// every verdict against a behavioral model kept in this bench or a hand-known answer.
// ----------------------------------------------------------------------------
module murmur3_bloom_filter_tb;
  localparam int LANES       = 6;
  localparam int STORE_WORDS = 1024;
  localparam int SIZE_CAP    = STORE_WORDS * 64;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [31:0] in_key_word;
  logic [2:0]  in_word_bytes;
  logic        in_last_word;
  logic        out_valid;
  logic        out_is_member;
  logic        out_was_add;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  murmur3_bloom_filter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_key_word(in_key_word), .in_word_bytes(in_word_bytes),
    .in_last_word(in_last_word), .out_valid(out_valid),
    .out_is_member(out_is_member), .out_was_add(out_was_add),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // One expected verdict: the membership answer and the echoed mode.
  typedef struct {
    logic member;
    logic was_add;
  } verdict_t;

  // A row of the directed table. A known verdict of -1 means the bench model
  // decides; otherwise the value is the answer one can read off by hand.
  typedef struct {
    logic        mode;
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    int          known_member;
  } beat_row_t;

  verdict_t pending_verdicts[$];

  // Bench copy of the filter: settings, bit store and per-key hash state.
  logic [16:0] bits_setting;
  logic [2:0]  count_setting;
  logic [31:0] seeds [LANES];
  logic [63:0] filter_words [STORE_WORDS];
  logic [31:0] lane_hash [LANES];
  logic [31:0] key_bytes;
  logic        key_open;

  int mismatches;
  int verdicts_seen;
  int beats_sent;
  int keys_sent;

  function automatic logic [31:0] scramble_word(logic [31:0] k);
    k = k * mbf_pkg::MIX_C1;
    k = {k[16:0], k[31:17]};
    return k * mbf_pkg::MIX_C2;
  endfunction

  function automatic logic [31:0] final_mix(logic [31:0] h, logic [31:0] len);
    h = h ^ len;
    h = h ^ (h >> 16);
    h = h * mbf_pkg::FIN_C1;
    h = h ^ (h >> 13);
    h = h * mbf_pkg::FIN_C2;
    return h ^ (h >> 16);
  endfunction

  function automatic void filter_clear_state();
    bits_setting  = 17'd65536;
    count_setting = 3'd6;
    key_bytes     = '0;
    key_open      = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      seeds[i] = '0;
      lane_hash[i] = '0;
    end
    for (int i = 0; i < STORE_WORDS; i++) filter_words[i] = '0;
  endfunction

  function automatic void filter_set_reg(logic [2:0] idx, logic [31:0] value);
    if (idx == mbf_pkg::CFG_FILTER_BITS) bits_setting = value[16:0];
    else if (idx == mbf_pkg::CFG_HASH_COUNT) count_setting = value[2:0];
    else seeds[idx - mbf_pkg::CFG_SEED_ZERO] = value;
  endfunction

  // Absorbs one key word into every lane and, on the last word, probes the
  // store and returns the verdict. Returns 0 when the beat gives no result.
  function automatic bit filter_absorb(logic mode, logic [31:0] word, logic [2:0] nb,
                                       logic last, output verdict_t v);
    logic [31:0] k;
    logic [31:0] size;
    logic [31:0] pos [LANES];
    int          count;
    logic        member;
    if (!key_open) begin
      for (int i = 0; i < LANES; i++) lane_hash[i] = seeds[i];
      key_bytes = '0;
      key_open  = 1'b1;
    end
    // Inner words always count as full, and oversized counts clamp to four.
    if (!last || nb > 3'd4) nb = 3'd4;
    if (nb == 3'd4) begin
      k = scramble_word(word);
      for (int i = 0; i < LANES; i++) begin
        lane_hash[i] = lane_hash[i] ^ k;
        lane_hash[i] = {lane_hash[i][18:0], lane_hash[i][31:19]} * 32'd5 + mbf_pkg::MIX_N;
      end
    end else if (nb != 3'd0) begin
      k = scramble_word(word & ((32'd1 << (8 * nb)) - 32'd1));
      for (int i = 0; i < LANES; i++) lane_hash[i] = lane_hash[i] ^ k;
    end
    key_bytes = key_bytes + 32'(nb);
    if (!last) return 0;
    size = {15'd0, bits_setting} & ~32'd63;
    if (size < 32'd64) size = 32'd64;
    if (size > SIZE_CAP) size = SIZE_CAP;
    count = (count_setting > LANES) ? LANES : int'(count_setting);
    member = 1'b1;
    for (int i = 0; i < count; i++) begin
      pos[i] = final_mix(lane_hash[i], key_bytes) % size;
      if (!filter_words[pos[i] >> 6][pos[i][5:0]]) member = 1'b0;
    end
    if (mode)
      for (int i = 0; i < count; i++) filter_words[pos[i] >> 6][pos[i][5:0]] = 1'b1;
    v.member  = member;
    v.was_add = mode;
    key_open  = 1'b0;
    return 1;
  endfunction

  // Result checker. The block cannot be stalled, so every strobe is a beat.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_is_member !== want.member || out_was_add !== want.was_add) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch at %0t: member exp %0b got %0b, add exp %0b got %0b",
                     $realtime, want.member, out_is_member, want.was_add, out_was_add);
        end
      end
    end
  end

  // Sender idle percentage; nonzero values put gaps between beats.
  int idle_pct;

  // Presents one beat and holds it until the block takes it. Start is left
  // high so that a following beat can go out back to back.
  task automatic send_beat(logic mode, logic [31:0] word, logic [2:0] nb, logic last,
                           int known_member);
    verdict_t v;
    start         <= 1'b1;
    in_mode       <= mode;
    in_key_word   <= word;
    in_word_bytes <= nb;
    in_last_word  <= last;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (filter_absorb(mode, word, nb, last, v)) begin
      keys_sent++;
      if (known_member >= 0) v.member = known_member[0];
      pending_verdicts = {pending_verdicts, v};
    end
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Lets every expected verdict arrive and the block fall idle before the
  // settings change.
  task automatic drain_to_idle();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(logic [31:0] fbits, logic [31:0] hcount, bit random_seeds,
                                logic [31:0] seed_fill);
    logic [31:0] value;
    for (int idx = 0; idx < 2 + LANES; idx++) begin
      if (idx == mbf_pkg::CFG_FILTER_BITS) value = fbits;
      else if (idx == mbf_pkg::CFG_HASH_COUNT) value = hcount;
      else value = random_seeds ? $urandom() : seed_fill;
      cfg_we    <= 1'b1;
      cfg_index <= 3'(idx);
      cfg_data  <= value;
      @(posedge clk);
      filter_set_reg(3'(idx), value);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Sends one key. Most keys are short with a random tail; a few are long.
  // Inner words carry random byte counts, which the block must treat as full.
  task automatic send_random_key();
    int words;
    words = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
    for (int w = 1; w < words; w++)
      send_beat($urandom_range(1), pick_word(), 3'($urandom_range(7)), 1'b0, -1);
    send_beat($urandom_range(1), pick_word(), 3'($urandom_range(7)), 1'b1, -1);
  endtask

  // Directed table. After reset the filter is empty with all six lanes active,
  // so the first query misses; adding a key and querying it again must hit.
  beat_row_t directed_rows[16] = '{
    '{1'b0, 32'h0000_0000, 3'd0, 1'b1, 0},  // empty key, empty filter: miss
    '{1'b1, 32'hdead_beef, 3'd0, 1'b1, 0},  // add the empty key
    '{1'b0, 32'h1234_5678, 3'd0, 1'b1, 1},  // empty key present; word ignored
    '{1'b1, 32'hffff_ffff, 3'd4, 1'b1, -1},
    '{1'b0, 32'hffff_ffff, 3'd4, 1'b1, 1},  // same full word queried back
    '{1'b0, 32'h0000_0000, 3'd4, 1'b0, -1},
    '{1'b1, 32'h1234_5678, 3'd1, 1'b1, -1},
    '{1'b1, 32'h8765_4321, 3'd2, 1'b1, -1},
    '{1'b0, 32'habcd_ef01, 3'd3, 1'b1, -1},
    '{1'b1, 32'h5555_aaaa, 3'd1, 1'b0, -1}, // short inner word counts as four
    '{1'b0, 32'haaaa_5555, 3'd7, 1'b1, -1}, // oversized tail clamps to four
    '{1'b1, 32'h0f0f_0f0f, 3'd5, 1'b1, -1},
    '{1'b0, 32'h0f0f_0f0f, 3'd6, 1'b1, 1},  // five and six both mean four
    '{1'b0, 32'hffff_ffff, 3'd4, 1'b0, -1},
    '{1'b0, 32'hffff_ffff, 3'd4, 1'b0, -1},
    '{1'b1, 32'h0000_0001, 3'd4, 1'b1, -1}
  };

  // Random phases: filter size, hash count, seeding and sender idling.
  // The list covers the smallest and largest sizes, odd and oversized size
  // writes, a zero hash count that always answers present, and a count
  // beyond the lane count.
  int phase_bits  [6] = '{64, 65536, 100, 0, 131071, 4096};
  int phase_count [6] = '{1, 6, 7, 0, 3, 4};
  int phase_idle  [6] = '{0, 70, 34, 0, 70, 34};
  int phase_keys  [6] = '{50, 50, 40, 20, 50, 50};

  initial begin
    rst_n = 1'b0; start = 1'b0; in_mode = 1'b0; in_key_word = '0;
    in_word_bytes = '0; in_last_word = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatches = 0; verdicts_seen = 0; beats_sent = 0; keys_sent = 0; idle_pct = 0;
    filter_clear_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // The store clears itself after reset while busy is high.
    do @(posedge clk); while (busy);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].mode, directed_rows[i].word, directed_rows[i].nbytes,
                directed_rows[i].last, directed_rows[i].known_member);
    drain_to_idle();

    for (int p = 0; p < 6; p++) begin
      write_settings(phase_bits[p], phase_count[p], p != 1, 32'hffff_ffff);
      idle_pct = phase_idle[p];
      for (int k = 0; k < phase_keys[p]; k++) send_random_key();
      drain_to_idle();
    end

    repeat (300) @(posedge clk);
    $display("Sent %0d beats in %0d keys over seven filter settings; %0d verdicts checked.",
             beats_sent, keys_sent, verdicts_seen);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d verdicts never seen", mismatches, pending_verdicts.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbf_pkg.sv
rtl/mbf_mul.sv
rtl/mbf_mod.sv
rtl/murmur3_bloom_filter.sv
rtl/mbf_checker.sv
tb/murmur3_bloom_filter_tb.sv
